// ===== hw/rtl/pvs_pkg.sv =====
// Package for the polynomial value and slope block.
// Holds word widths, register indexes, pipeline payload types and saturation.
// No dependencies.
package pvs_pkg;

  // Fixed field widths
  localparam int DATA_W   = 32;
  localparam int WIDE_W   = 64;
  localparam int DEG_W    = 3;
  localparam int IDX_W    = 3;
  localparam int NUM_COEF = 6;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_DEGREE = 3'd0;
  localparam logic [IDX_W-1:0] CFG_COEF0  = 3'd1;

  localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd3;

  localparam longint WORD_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint WORD_MIN = -(longint'(1) <<< (DATA_W - 1));

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // Saturated word and its clamp flag
  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_t;

  // Item between cells: point, value and slope accumulators, overflow so far
  typedef struct packed {
    word_t x;
    word_t val;
    word_t slp;
    logic  ovf;
  } item_t;

  // Item inside a cell after the multiply stage
  typedef struct packed {
    word_t x;
    wide_t pv;
    wide_t ps;
    word_t slp;
    logic  ovf;
  } prod_t;

  // Clamp a wide signed value to the word range
  function automatic sat_t sat_word(input wide_t v);
    sat_t r;
    if (v > wide_t'(WORD_MAX)) begin
      r.val = word_t'(WORD_MAX);
      r.ovf = 1'b1;
    end else if (v < wide_t'(WORD_MIN)) begin
      r.val = word_t'(WORD_MIN);
      r.ovf = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pvs_weights.sv =====
// Coefficient preparation for the Horner cell chain.
// Masks coefficients above the degree in use and forms derivative weights j*a[j].
// Depends on pvs_pkg.
module pvs_weights #(
  parameter int MAX_DEGREE = 5
) (
  input  logic [pvs_pkg::DEG_W-1:0] degree_i,
  input  pvs_pkg::word_t            coef_i     [pvs_pkg::NUM_COEF],
  output logic [pvs_pkg::DEG_W-1:0] deg_eff_o,
  output pvs_pkg::word_t            coef_eff_o [MAX_DEGREE+1],
  output pvs_pkg::word_t            weight_o   [MAX_DEGREE:1],
  output logic                      wovf_o
);

  logic [pvs_pkg::DEG_W-1:0] deg_eff;
  logic [MAX_DEGREE:1]       wovf_vec;

  // Degree clamped to what the chain can hold
  assign deg_eff   = (degree_i > pvs_pkg::DEG_W'(MAX_DEGREE)) ?
                     pvs_pkg::DEG_W'(MAX_DEGREE) : degree_i;
  assign deg_eff_o = deg_eff;

  for (genvar j = 0; j <= MAX_DEGREE; j++) begin : g_coef
    if (j < pvs_pkg::NUM_COEF) begin : g_reg
      // Coefficient in use only up to the degree; higher terms act as zero
      assign coef_eff_o[j] = (pvs_pkg::DEG_W'(j) <= deg_eff) ? coef_i[j] : '0;
    end else begin : g_zero
      assign coef_eff_o[j] = '0;
    end
  end

  for (genvar j = 1; j <= MAX_DEGREE; j++) begin : g_weight
    if (j < pvs_pkg::NUM_COEF) begin : g_reg
      pvs_pkg::wide_t wide;
      pvs_pkg::sat_t  w;
      // Constant multiply by j, clamped; flags count only for terms in use
      assign wide = pvs_pkg::wide_t'(coef_i[j]) * pvs_pkg::wide_t'(j);
      assign w    = pvs_pkg::sat_word(wide);
      assign weight_o[j] = (pvs_pkg::DEG_W'(j) <= deg_eff) ? w.val : '0;
      assign wovf_vec[j] = (pvs_pkg::DEG_W'(j) <= deg_eff) & w.ovf;
    end else begin : g_zero
      assign weight_o[j] = '0;
      assign wovf_vec[j] = 1'b0;
    end
  end

  assign wovf_o = |wovf_vec;

endmodule

// ===== hw/rtl/pvs_cell.sv =====
// One Horner cell: acc*x, arithmetic shift, clamp, add coefficient, clamp.
// Two register stages (product, then sum) with a per-stage valid/ready chain.
// Depends on pvs_pkg.
module pvs_cell #(
  parameter int FRAC_BITS = 16,
  parameter bit SLOPE_EN  = 1'b1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pvs_pkg::item_t in_item_i,
  input  pvs_pkg::word_t coef_i,
  input  pvs_pkg::word_t weight_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pvs_pkg::item_t out_item_o
);

  logic            a_valid_q, b_valid_q;
  logic            a_ready, b_ready;
  pvs_pkg::prod_t  a_d, a_q;
  pvs_pkg::item_t  b_d, b_q;

  // Each stage takes new data when empty or when its content moves on
  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Multiply stage
  always_comb begin
    a_d.x   = in_item_i.x;
    a_d.pv  = pvs_pkg::wide_t'($signed(in_item_i.val)) *
              pvs_pkg::wide_t'($signed(in_item_i.x));
    a_d.ps  = SLOPE_EN ? pvs_pkg::wide_t'($signed(in_item_i.slp)) *
                         pvs_pkg::wide_t'($signed(in_item_i.x)) : '0;
    a_d.slp = in_item_i.slp;
    a_d.ovf = in_item_i.ovf;
  end

  // Shift, clamp, add, clamp
  always_comb begin
    pvs_pkg::sat_t v1, v2, s1, s2;
    v1 = pvs_pkg::sat_word($signed(a_q.pv) >>> FRAC_BITS);
    v2 = pvs_pkg::sat_word(pvs_pkg::wide_t'($signed(v1.val)) +
                           pvs_pkg::wide_t'($signed(coef_i)));
    s1 = pvs_pkg::sat_word($signed(a_q.ps) >>> FRAC_BITS);
    s2 = pvs_pkg::sat_word(pvs_pkg::wide_t'($signed(s1.val)) +
                           pvs_pkg::wide_t'($signed(weight_i)));
    b_d.x   = a_q.x;
    b_d.val = v2.val;
    b_d.slp = SLOPE_EN ? s2.val : a_q.slp;
    b_d.ovf = a_q.ovf | v1.ovf | v2.ovf | (SLOPE_EN & (s1.ovf | s2.ovf));
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) a_q <= a_d;
    if (a_valid_q && b_ready)  b_q <= b_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_q;

endmodule

// ===== hw/rtl/polynomial_value_and_slope.sv =====
// Polynomial value and slope: p(x) and p'(x) by Horner's rule, signed Q16.16.
// Top level: configuration registers, coefficient preparation, cell chain.
// Depends on pvs_pkg, pvs_weights, pvs_cell.
//
// Accepts one sample point per clock cycle while the output takes results and
// returns one result per point in order. The point passes a chain of MAX_DEGREE
// Horner cells, each with a multiply stage and a shift/clamp/add stage, so
// 2*MAX_DEGREE registers in all. Every stage stalls on its own, so the block
// keeps taking points while a result waits at the output, until all
// 2*MAX_DEGREE stages are full. Degree is clamped to MAX_DEGREE; any clamp to
// the 32-bit range in value, slope or a derivative weight sets the overflow flag
// in tuser. Configuration writes take effect at once and belong in idle
// periods.
module polynomial_value_and_slope #(
  parameter int MAX_DEGREE = 5,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port
  input  logic                       cfg_we_i,
  input  logic [pvs_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [pvs_pkg::DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,   // [31:0] point
  // Output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,   // [31:0] value, [63:32] slope
  output logic                       m_axis_tuser    // [0] overflow
);

  localparam int STAGES = 2 * MAX_DEGREE;
  localparam int OCC_W  = $clog2(STAGES + 1);

  logic [pvs_pkg::DEG_W-1:0] degree_q;
  pvs_pkg::word_t            coef_q     [pvs_pkg::NUM_COEF];
  logic [pvs_pkg::DEG_W-1:0] deg_eff;
  pvs_pkg::word_t            coef_eff   [MAX_DEGREE+1];
  pvs_pkg::word_t            weight     [MAX_DEGREE:1];
  logic                      wovf;

  pvs_pkg::item_t            link       [MAX_DEGREE+1];
  logic                      link_valid [MAX_DEGREE+1];
  logic                      link_ready [MAX_DEGREE+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= pvs_pkg::DEGREE_RESET;
      for (int j = 0; j < pvs_pkg::NUM_COEF; j++) coef_q[j] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pvs_pkg::CFG_DEGREE) degree_q <= cfg_wdata_i[pvs_pkg::DEG_W-1:0];
      for (int j = 0; j < pvs_pkg::NUM_COEF; j++) begin
        if (cfg_idx_i == pvs_pkg::CFG_COEF0 + pvs_pkg::IDX_W'(j)) coef_q[j] <= cfg_wdata_i;
      end
    end
  end

  pvs_weights #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_weights (
    .degree_i   (degree_q),
    .coef_i     (coef_q),
    .deg_eff_o  (deg_eff),
    .coef_eff_o (coef_eff),
    .weight_o   (weight),
    .wovf_o     (wovf)
  );

  // Chain head: accumulators start at the top coefficient and top weight
  assign link_valid[0] = s_axis_tvalid;
  assign s_axis_tready = link_ready[0];
  assign link[0].x     = s_axis_tdata;
  assign link[0].val   = coef_eff[MAX_DEGREE];
  assign link[0].slp   = weight[MAX_DEGREE];
  assign link[0].ovf   = wovf;

  // Cell k folds in coefficient MAX_DEGREE-1-k; the last cell has no slope term
  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
    localparam int J = MAX_DEGREE - 1 - k;
    pvs_pkg::word_t w;
    if (J >= 1) begin : g_w
      assign w = weight[J];
    end else begin : g_nw
      assign w = '0;
    end
    pvs_cell #(
      .FRAC_BITS(FRAC_BITS),
      .SLOPE_EN (J >= 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[k]),
      .in_ready_o  (link_ready[k]),
      .in_item_i   (link[k]),
      .coef_i      (coef_eff[J]),
      .weight_i    (w),
      .out_valid_o (link_valid[k+1]),
      .out_ready_i (link_ready[k+1]),
      .out_item_o  (link[k+1])
    );
  end

  // Last cell's second stage is the output register
  assign link_ready[MAX_DEGREE] = m_axis_tready;
  assign m_axis_tvalid = link_valid[MAX_DEGREE];
  assign m_axis_tdata  = {link[MAX_DEGREE].slp, link[MAX_DEGREE].val};
  assign m_axis_tuser  = link[MAX_DEGREE].ovf;

  // Items in flight, for checking
  logic [OCC_W-1:0] occ_d, occ_q;
  always_comb begin
    occ_d = occ_q;
    if (s_axis_tvalid && s_axis_tready) occ_d = occ_d + OCC_W'(1);
    if (m_axis_tvalid && m_axis_tready) occ_d = occ_d - OCC_W'(1);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) occ_q <= '0;
    else         occ_q <= occ_d;
  end

  // An empty output register lets ready run back through the whole chain
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register is empty");

  // A full chain with a stalled output takes no new point
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == OCC_W'(STAGES) && !m_axis_tready) |-> !s_axis_tready)
    else $error("point accepted into a full chain");

  // A result on the output means an item is in flight, never more than stages
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || occ_q != '0) && (occ_q <= OCC_W'(STAGES)))
    else $error("items in flight out of range");

  // Degree zero uses no derivative weights, so they cannot flag overflow
  a_deg0_no_wovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deg_eff == '0) |-> !wovf)
    else $error("weight overflow at degree zero");

endmodule
